[src/cfd_pkg.sv]
// Shared types and constants for the command frame deframer.
`timescale 1ns / 1ps

package cfd_pkg;

    localparam int MAX_PAYLOAD_DEF = 60;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 6;
    localparam int FRAME_OVERHEAD  = 4;
    localparam int CMD_Q_DEPTH     = 2;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h01;
    localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'hFE;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BAD_END = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic {
        REG_START_MARKER = 1'b0,
        REG_END_MARKER   = 1'b1
    } reg_idx_t;

    // Command handed from the parser to the drain sequencer
    typedef struct packed {
        logic [BYTE_W-1:0] op;
        logic [LEN_W-1:0]  len;
        status_t           status;
        logic              drain;
    } cmd_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

[src/command_frame_deframer_core.sv]
// Top level: marker/length/end frame deframer with APB marker registers.
// A payload byte is held off while a previous drain runs.
// First result: command queue, then BK_READ and BK_WAIT with payload, then output register.
// Payload drain: BK_READ, BK_WAIT; a RAM read starts only once the output register is free.
// Error and empty-frame results: one transfer, via the command queue and output register.
// rst_n (async, low) clears parser, command queue, sequencer and markers (0x01 / 0xFE).
`timescale 1ns / 1ps

module command_frame_deframer_core #(
    parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [cfd_pkg::BYTE_W-1:0]        rx_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic [cfd_pkg::BYTE_W-1:0]        op_code,
    output logic [cfd_pkg::LEN_W-1:0]         payload_len,
    output logic [cfd_pkg::BYTE_W-1:0]        data_byte,
    output logic                              has_byte,
    output logic                              last_of_run,
    output logic [1:0]                        frame_status,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cfd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [cfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [cfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    import cfd_pkg::*;

    localparam int AW = addr_w(MAX_PAYLOAD);

    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] end_marker_reg;
    reg_idx_t          reg_sel;
    logic              apb_write;

    logic              back_pending;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              cmd_push;
    cmd_t              cmd_in;
    logic              cmd_full;
    logic              cmd_pop;
    cmd_t              cmd_out;
    logic              cmd_empty;

    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[2]);
    assign apb_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            REG_START_MARKER: prdata = APB_DATA_W'(start_marker_reg);
            REG_END_MARKER:   prdata = APB_DATA_W'(end_marker_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RESET;
            end_marker_reg   <= END_MARKER_RESET;
        end
        else if (apb_write)
        begin
            case (reg_sel)
                REG_START_MARKER: start_marker_reg <= pwdata[BYTE_W-1:0];
                REG_END_MARKER:   end_marker_reg   <= pwdata[BYTE_W-1:0];
                default:          start_marker_reg <= start_marker_reg;
            endcase
        end
    end

    cfd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .back_pending (back_pending),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_in),
        .cmd_full     (cmd_full)
    );

    cfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cfd_cmd_fifo #(
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    cfd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmd_empty),
        .cmd_data     (cmd_out),
        .cmd_pop      (cmd_pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .pending      (back_pending),
        .pop          (pop),
        .empty        (empty),
        .op_code      (op_code),
        .payload_len  (payload_len),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .last_of_run  (last_of_run),
        .frame_status (frame_status)
    );

endmodule

[src/cfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 60
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [cfd_pkg::addr_w(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [cfd_pkg::addr_w(DEPTH)-1:0]     raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/cfd_front.sv]
// Frame parser: header decode, payload capture, command issue.
`timescale 1ns / 1ps

module cfd_front #(
    parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [cfd_pkg::BYTE_W-1:0]             rx_byte,
    input  logic [cfd_pkg::BYTE_W-1:0]             start_marker,
    input  logic [cfd_pkg::BYTE_W-1:0]             end_marker,
    input  logic                                   back_pending,
    output logic                                   ram_we,
    output logic [cfd_pkg::addr_w(MAX_PAYLOAD)-1:0] ram_waddr,
    output logic [cfd_pkg::BYTE_W-1:0]             ram_wdata,
    output logic                                   cmd_push,
    output cfd_pkg::cmd_t                          cmd_data,
    input  logic                                   cmd_full
);

    import cfd_pkg::*;

    localparam int AW = addr_w(MAX_PAYLOAD);
    localparam logic [BYTE_W-1:0] LEN_MIN = BYTE_W'(FRAME_OVERHEAD);
    localparam logic [BYTE_W-1:0] LEN_MAX = BYTE_W'(MAX_PAYLOAD + FRAME_OVERHEAD);
    localparam logic [LEN_W-1:0]  CNT_MAX = LEN_W'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_OP    = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_END   = 3'd4
    } phase_t;

    phase_t             phase_reg;
    logic               header_good_reg;
    logic [BYTE_W-1:0]  held_op_reg;
    logic [LEN_W-1:0]   held_len_reg;
    logic [LEN_W-1:0]   byte_count_reg;

    logic               accept;
    logic               len_bad;
    logic [LEN_W-1:0]   count_next;

    assign full       = cmd_full || ((phase_reg == PH_DATA) && back_pending);
    assign accept     = push && !full;
    assign len_bad    = (rx_byte < LEN_MIN) || (rx_byte > LEN_MAX);
    assign count_next = byte_count_reg + LEN_W'(1);

    assign ram_we    = accept && (phase_reg == PH_DATA) && (byte_count_reg < CNT_MAX);
    assign ram_waddr = byte_count_reg[AW-1:0];
    assign ram_wdata = rx_byte;

    always_comb
    begin
        cmd_push        = 1'b0;
        cmd_data.op     = held_op_reg;
        cmd_data.len    = held_len_reg;
        cmd_data.status = ST_GOOD;
        cmd_data.drain  = 1'b0;
        case (phase_reg)
            PH_LEN:
            begin
                cmd_push        = accept && header_good_reg && len_bad;
                cmd_data.len    = '0;
                cmd_data.status = ST_RANGE;
            end
            PH_END:
            begin
                cmd_push = accept;
                if (rx_byte != end_marker)
                begin
                    cmd_data.status = ST_BAD_END;
                end
                else
                begin
                    cmd_data.drain = (held_len_reg != '0);
                end
            end
            default:
            begin
                cmd_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            header_good_reg <= 1'b0;
            held_op_reg     <= '0;
            held_len_reg    <= '0;
            byte_count_reg  <= '0;
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_OP:
                begin
                    held_op_reg <= rx_byte;
                    phase_reg   <= PH_LEN;
                end
                PH_LEN:
                begin
                    phase_reg <= PH_START;
                    if (header_good_reg && !len_bad)
                    begin
                        held_len_reg   <= LEN_W'(rx_byte - LEN_MIN);
                        byte_count_reg <= '0;
                        phase_reg      <= (rx_byte == LEN_MIN) ? PH_END : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    byte_count_reg <= count_next;
                    if (count_next >= held_len_reg)
                    begin
                        phase_reg <= PH_END;
                    end
                end
                PH_END:
                begin
                    phase_reg <= PH_START;
                end
                default:
                begin
                    header_good_reg <= (rx_byte == start_marker);
                    phase_reg       <= PH_OP;
                end
            endcase
        end
    end

endmodule

[src/cfd_cmd_fifo.sv]
// Short command queue between the parser and the drain sequencer.
`timescale 1ns / 1ps

module cfd_cmd_fifo #(
    parameter int DEPTH = cfd_pkg::CMD_Q_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfd_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output cfd_pkg::cmd_t dout,
    output logic          empty
);

    import cfd_pkg::*;

    localparam int PW = addr_w(DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [PW:0]   FULL_CNT = (PW + 1)'(DEPTH);

    cmd_t           entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (PW + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (PW + 1)'(1);
            end
        end
    end

endmodule

[src/cfd_back.sv]
// Drain sequencer: turns commands into result transfers, reading payload from RAM.
`timescale 1ns / 1ps

module cfd_back #(
    parameter int MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cmd_empty,
    input  cfd_pkg::cmd_t                           cmd_data,
    output logic                                    cmd_pop,
    output logic                                    ram_re,
    output logic [cfd_pkg::addr_w(MAX_PAYLOAD)-1:0] ram_raddr,
    input  logic [cfd_pkg::BYTE_W-1:0]              ram_rdata,
    output logic                                    pending,
    input  logic                                    pop,
    output logic                                    empty,
    output logic [cfd_pkg::BYTE_W-1:0]              op_code,
    output logic [cfd_pkg::LEN_W-1:0]               payload_len,
    output logic [cfd_pkg::BYTE_W-1:0]              data_byte,
    output logic                                    has_byte,
    output logic                                    last_of_run,
    output logic [1:0]                              frame_status
);

    import cfd_pkg::*;

    localparam int AW = addr_w(MAX_PAYLOAD);

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_WAIT = 2'd2
    } back_state_t;

    back_state_t        state_reg;
    cmd_t               cur_reg;
    logic [LEN_W-1:0]   idx_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_op_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [BYTE_W-1:0]  out_data_reg;
    logic               out_has_reg;
    logic               out_last_reg;
    status_t            out_status_reg;

    logic [LEN_W-1:0]   idx_next;
    logic               is_last;

    assign idx_next  = idx_reg + LEN_W'(1);
    assign is_last   = (idx_next == cur_reg.len);
    assign cmd_pop   = (state_reg == BK_IDLE) && !cmd_empty && !out_valid_reg;
    assign ram_re    = (state_reg == BK_READ) && !out_valid_reg;
    assign ram_raddr = idx_reg[AW-1:0];
    assign pending   = (state_reg != BK_IDLE) || !cmd_empty;

    assign empty        = !out_valid_reg;
    assign op_code      = out_op_reg;
    assign payload_len  = out_len_reg;
    assign data_byte    = out_data_reg;
    assign has_byte     = out_has_reg;
    assign last_of_run  = out_last_reg;
    assign frame_status = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            cur_reg        <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_op_reg     <= '0;
            out_len_reg    <= '0;
            out_data_reg   <= '0;
            out_has_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
            out_status_reg <= ST_GOOD;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                BK_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        if (cmd_data.drain)
                        begin
                            cur_reg   <= cmd_data;
                            idx_reg   <= '0;
                            state_reg <= BK_READ;
                        end
                        else
                        begin
                            out_valid_reg  <= 1'b1;
                            out_op_reg     <= cmd_data.op;
                            out_len_reg    <= cmd_data.len;
                            out_data_reg   <= '0;
                            out_has_reg    <= 1'b0;
                            out_last_reg   <= 1'b1;
                            out_status_reg <= cmd_data.status;
                        end
                    end
                end
                BK_READ:
                begin
                    if (ram_re)
                    begin
                        state_reg <= BK_WAIT;
                    end
                end
                BK_WAIT:
                begin
                    out_valid_reg  <= 1'b1;
                    out_op_reg     <= cur_reg.op;
                    out_len_reg    <= cur_reg.len;
                    out_data_reg   <= ram_rdata;
                    out_has_reg    <= 1'b1;
                    out_last_reg   <= is_last;
                    out_status_reg <= ST_GOOD;
                    idx_reg        <= idx_next;
                    state_reg      <= is_last ? BK_IDLE : BK_READ;
                end
                default:
                begin
                    state_reg <= BK_IDLE;
                end
            endcase
        end
    end

endmodule
